### sv/gwwb_pkg.sv
package gwwb_pkg;

  localparam int PIX_W = 8;
  localparam int SUM_W = 32;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // floor(x / 3) == (x * 683) >> 11 for every x below 2048
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_end;
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MEAN,
    ST_TARGET,
    ST_CORR
  } back_state_t;

endpackage

### sv/gwwb_div.sv
module gwwb_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 25
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   rem;
  logic [NUM_W-1:0] q;
  logic [DEN_W-1:0] d;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;

  assign shifted = {rem[DEN_W-1:0], q[NUM_W-1]};
  assign diff    = shifted - {1'b0, d};
  assign quo     = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
        rem  <= '0;
        q    <= num;
        d    <= den;
      end else if (busy) begin
        if (!diff[DEN_W]) begin
          rem <= diff;
          q   <= {q[NUM_W-2:0], 1'b1};
        end else begin
          rem <= shifted;
          q   <= {q[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### sv/gwwb_fifo.sv
module gwwb_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  gwwb_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_ready,
  output gwwb_pkg::req_t out_req
);
  import gwwb_pkg::*;

  req_t       mem [2];
  logic       wptr, rptr;
  logic [1:0] cnt;
  logic       push, pop;

  assign in_ready  = cnt != 2'd2;
  assign out_valid = cnt != 2'd0;
  assign out_req   = mem[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= in_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= '0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### sv/gwwb_back.sv
module gwwb_back #(
  parameter int PIXEL_COUNT_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  gwwb_pkg::req_t       req,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_r,
  output logic [7:0]           out_g,
  output logic [7:0]           out_b
);
  import gwwb_pkg::*;

  localparam int CNT_W = PIXEL_COUNT_BITS + 1;
  localparam logic [CNT_W-1:0] BOUND = CNT_W'(1) << PIXEL_COUNT_BITS;

  back_state_t state, state_next;

  logic [SUM_W-1:0] sum [3];
  logic [CNT_W-1:0] count;
  logic [PIX_W-1:0] mean [3];
  logic [PIX_W-1:0] target;
  logic [PIX_W-1:0] pix [3];
  logic [PIX_W-1:0] res [3];
  logic [1:0]       ch;
  logic [9:0]       msum;
  logic [19:0]      tprod;

  logic             div_start, div_busy, div_done;
  logic [SUM_W-1:0] div_num, div_quo;
  logic [CNT_W-1:0] div_den;

  logic take, counting;

  gwwb_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .done(div_done), .quo(div_quo)
  );

  assign req_ready = state == ST_IDLE && !out_valid;
  assign take      = req_valid && req_ready;
  assign counting  = count < BOUND;
  assign msum      = 10'(mean[0]) + 10'(mean[1]) + 10'(mean[2]);
  assign tprod     = 20'(msum) * 20'(DIV3_MUL);
  assign out_r = res[0];
  assign out_g = res[1];
  assign out_b = res[2];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take && req.mode) state_next = ST_CORR;
        else if (take && req.frame_end) state_next = ST_MEAN;
      end
      ST_MEAN: begin
        if (div_done && ch == 2'd2) state_next = ST_TARGET;
      end
      ST_TARGET: begin
        state_next = ST_IDLE;
      end
      ST_CORR: begin
        if (div_done && ch == 2'd2) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state)
      ST_MEAN: begin
        div_start = !div_busy && !div_done;
        div_num   = sum[ch];
        div_den   = count;
      end
      ST_CORR: begin
        div_start = !div_busy && !div_done;
        div_num   = SUM_W'(16'(pix[ch]) * 16'(target));
        div_den   = CNT_W'(mean[ch]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      ch        <= '0;
      count     <= '0;
      target    <= '0;
      for (int i = 0; i < 3; i++) begin
        sum[i]  <= '0;
        mean[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          ch <= '0;
          if (take) begin
            pix[0] <= req.red;
            pix[1] <= req.green;
            pix[2] <= req.blue;
            if (!req.mode && counting) begin
              sum[0] <= sum[0] + SUM_W'(req.red);
              sum[1] <= sum[1] + SUM_W'(req.green);
              sum[2] <= sum[2] + SUM_W'(req.blue);
              count  <= count + 1'b1;
            end
            if (!req.mode && req.frame_end && count == '0 && !counting) begin
              count <= '0;
            end
          end
        end
        ST_MEAN: begin
          if (div_done) begin
            if (count == '0) mean[ch] <= '0;
            else if (div_quo > SUM_W'(PIX_MAX)) mean[ch] <= PIX_MAX;
            else mean[ch] <= div_quo[PIX_W-1:0];
            ch <= ch + 1'b1;
          end
        end
        ST_TARGET: begin
          target <= tprod[DIV3_SHIFT +: PIX_W];
          count  <= '0;
          for (int i = 0; i < 3; i++) sum[i] <= '0;
        end
        ST_CORR: begin
          if (div_done) begin
            if (mean[ch] == '0) res[ch] <= '0;
            else if (div_quo > SUM_W'(PIX_MAX)) res[ch] <= PIX_MAX;
            else res[ch] <= div_quo[PIX_W-1:0];
            ch <= ch + 1'b1;
            if (ch == 2'd2) out_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

### sv/gray_world_white_balance.sv
// Gray-world white balance, two passes over an 8-bit RGB image.
// Input channel: valid/ready with mode, red, green, blue, frame_end.
// Mode 0 adds the pixel to per-channel sums (up to 2^PIXEL_COUNT_BITS
// pixels); frame_end on a mode 0 pixel computes the channel means and the
// gray target and clears the sums. Mode 1 returns one corrected pixel on
// the output channel (out_red, out_green, out_blue, valid/ready).
// A two-entry request queue decouples input acceptance from the back end.
// The back end runs one shared 32-step restoring divider and starts a new
// division only once the last one is done:
//   accumulate pixel: sums and count update as the request is taken
//   frame end: 3 divisions, then the target step
//   correct pixel: 3 divisions, then out_valid is raised.
// Synchronous reset clears sums, count, means and target to zero; the
// correction pass before any frame gives zeros.
// A stalled output holds its result and the back end takes no new request
// until it is delivered; the queue keeps accepting until full.
module gray_world_white_balance #(
  parameter int PIXEL_COUNT_BITS = 24
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       mode,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic       frame_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);
  import gwwb_pkg::*;

  req_t in_req, q_req;
  logic q_valid, q_ready;

  assign in_req = '{mode: mode, red: red, green: green, blue: blue, frame_end: frame_end};

  gwwb_fifo u_fifo (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_req(in_req), .out_valid(q_valid), .out_ready(q_ready), .out_req(q_req)
  );

  gwwb_back #(.PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)) u_back (
    .clk(clk), .rst(rst), .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_r(out_red), .out_g(out_green), .out_b(out_blue)
  );

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_red))
    else $error("result dropped while stalled");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !q_ready)
    else $error("back end took request with pending result");
`endif
endmodule
